// File: design/bha_pkg.sv
// Shared types and constants for the bucketed hash aggregator.
// No dependencies.
package bha_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SLOT_W      = 12;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 112;
    localparam int unsigned AGG_W       = 3 * WORD_W;

    localparam logic [WORD_W-1:0] HASH_MULT = 32'd2654435769;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_NEW  = 2'd0;
    localparam status_t ST_HIT  = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
        logic hash;
        logic bucket;
        logic row_rd;
        logic match;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: design/bha_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bha_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bha_ctrl.sv
// Sequencer for the aggregator: clearing pass, then one item at a time.
// Depends on bha_pkg.
module bha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bha_pkg::dp_stat_t stat,
    output bha_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_BUCKET = 7'b0001000,
        S_READ   = 7'b0010000,
        S_MATCH  = 7'b0100000,
        S_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = S_BUCKET;
            end
            S_BUCKET:
            begin
                cmd.bucket = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: design/bha_datapath.sv
// Datapath: hashing, bucket row compare, aggregate update, output register.
// Depends on bha_pkg and bha_ram.
module bha_datapath #(
    parameter int unsigned NUM_BUCKETS  = 256,
    parameter int unsigned BUCKET_SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bha_pkg::dp_cmd_t                  cmd,
    output bha_pkg::dp_stat_t                 stat,
    input  logic [bha_pkg::IN_TDATA_W-1:0]    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bha_pkg::OUT_TDATA_W-1:0]   out_data,
    output bha_pkg::status_t                  out_status
);

    localparam int unsigned W    = bha_pkg::WORD_W;
    localparam int unsigned BW   = $clog2(NUM_BUCKETS);
    localparam int unsigned SW   = $clog2(BUCKET_SLOTS);
    localparam int unsigned TBL  = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int unsigned IW   = $clog2(TBL);
    localparam int unsigned ROWW = BUCKET_SLOTS * W;
    localparam int unsigned AW   = bha_pkg::AGG_W;
    localparam int unsigned OUT_TDATA_W_L = bha_pkg::OUT_TDATA_W;

    logic [W-1:0]  key_reg, val_reg, hash_reg, sq_reg;
    logic [BW-1:0] bucket_reg, clr_addr_reg;
    logic [SW-1:0] sel_reg;
    logic [IW-1:0] idx_reg;
    logic          found_reg, fresh_reg;
    logic          out_valid_reg;
    logic [OUT_TDATA_W_L-1:0] out_data_reg;
    bha_pkg::status_t out_status_reg;

    logic [BUCKET_SLOTS-1:0] vrow_rd, vrow_wr;
    logic [ROWW-1:0]         krow_rd, krow_wr;
    logic [AW-1:0]           agg_rd, agg_wr;
    logic [BUCKET_SLOTS-1:0] hit;
    logic [SW-1:0]           sel;
    logic [IW-1:0]           idx;
    logic [63:0]             bprod;
    logic [W-1:0]            cnt_new, sum_new, sq_new;
    logic [W-1:0]            idx_word;
    logic                    v_we;
    logic [BW-1:0]           v_waddr;

    assign bprod = 64'(hash_reg) * 64'(NUM_BUCKETS);

    always_comb
    begin
        for (int s = 0; s < BUCKET_SLOTS; s++)
        begin
            hit[s] = !vrow_rd[s] || (krow_rd[s*W +: W] == key_reg);
        end
        sel = '0;
        for (int s = BUCKET_SLOTS - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                sel = SW'(s);
            end
        end
        idx = IW'(bucket_reg) * IW'(BUCKET_SLOTS) + IW'(sel);
    end

    always_comb
    begin
        if (fresh_reg)
        begin
            cnt_new = W'(1);
            sum_new = val_reg;
            sq_new  = sq_reg;
        end
        else
        begin
            cnt_new = agg_rd[W-1:0] + W'(1);
            sum_new = agg_rd[W +: W] + val_reg;
            sq_new  = agg_rd[2*W +: W] + sq_reg;
        end
        agg_wr  = {sq_new, sum_new, cnt_new};
        vrow_wr = vrow_rd;
        vrow_wr[sel_reg] = 1'b1;
        krow_wr = krow_rd;
        krow_wr[sel_reg*W +: W] = key_reg;
        idx_word = W'(idx_reg);
    end

    assign v_we    = cmd.clear || (cmd.commit && found_reg);
    assign v_waddr = cmd.clear ? clr_addr_reg : bucket_reg;

    bha_ram #(.WIDTH(BUCKET_SLOTS), .DEPTH(NUM_BUCKETS)) u_valid_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (cmd.clear ? '0 : vrow_wr),
        .re    (cmd.row_rd),
        .raddr (bucket_reg),
        .rdata (vrow_rd)
    );

    bha_ram #(.WIDTH(ROWW), .DEPTH(NUM_BUCKETS)) u_key_ram (
        .clk   (clk),
        .we    (cmd.commit && found_reg && fresh_reg),
        .waddr (bucket_reg),
        .wdata (krow_wr),
        .re    (cmd.row_rd),
        .raddr (bucket_reg),
        .rdata (krow_rd)
    );

    bha_ram #(.WIDTH(AW), .DEPTH(TBL)) u_agg_ram (
        .clk   (clk),
        .we    (cmd.commit && found_reg),
        .waddr (idx_reg),
        .wdata (agg_wr),
        .re    (cmd.match),
        .raddr (idx),
        .rdata (agg_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_data[W-1:0];
            val_reg <= in_data[W +: W];
        end
        if (cmd.hash)
        begin
            hash_reg <= W'(key_reg * bha_pkg::HASH_MULT);
            sq_reg   <= W'(val_reg * val_reg);
        end
        if (cmd.bucket)
        begin
            bucket_reg <= bprod[W +: BW];
        end
        if (cmd.match)
        begin
            sel_reg   <= sel;
            idx_reg   <= idx;
            found_reg <= |hit;
            fresh_reg <= !vrow_rd[sel];
        end
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                out_status_reg <= fresh_reg ? bha_pkg::ST_NEW : bha_pkg::ST_HIT;
                out_data_reg   <= {4'b0, sq_new, sum_new, cnt_new,
                                   idx_word[bha_pkg::SLOT_W-1:0]};
            end
            else
            begin
                out_status_reg <= bha_pkg::ST_FULL;
                out_data_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + BW'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_addr_reg == BW'(NUM_BUCKETS - 1));
    assign stat.out_busy   = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_status      = out_status_reg;

endmodule

// File: design/bucketed_hash_aggregator.sv
// Top level of the bucketed hash group-by aggregator (count, sum, sum of squares).
// Depends on bha_pkg, bha_ctrl, bha_datapath, bha_ram.
//
// Input stream s_*: one beat per item, tdata = {item_value, group_key}.
// Output stream m_*: exactly one beat per input item, in order. tuser is the
// status (new group, existing group updated, bucket full). On a full bucket
// the item is dropped and the tdata fields are zero.
// Each item passes these steps on its way to the output register: key hash
// and value square multiply, bucket scaling multiply, bucket row read,
// parallel key compare with aggregate read, aggregate update and write.
// s_tready rises again in the cycle after that write, so an item is taken
// only once the last one is through; the sequencer holds one item at a time.
// The output register holds a finished beat while the next item is taken;
// if it is still full when the next result is ready the datapath waits.
// After reset all NUM_BUCKETS slot valid rows are cleared, one bucket per cycle,
// with s_tready low; the table then starts empty.
module bucketed_hash_aggregator #(
    parameter int unsigned NUM_BUCKETS  = 256,
    parameter int unsigned BUCKET_SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bha_pkg::IN_TDATA_W-1:0]    s_tdata,   // group_key, item_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bha_pkg::OUT_TDATA_W-1:0]   m_tdata,   // slot_index, group_count,
                                                         // group_sum, group_square_sum
    output logic [bha_pkg::STATUS_W-1:0]      m_tuser    // status
);

    bha_pkg::dp_cmd_t  cmd;
    bha_pkg::dp_stat_t stat;

    bha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bha_datapath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == bha_pkg::ST_NEW || m_tuser == bha_pkg::ST_HIT ||
                      m_tuser == bha_pkg::ST_FULL))
        else $error("bad status code");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bha_pkg::ST_FULL |-> m_tdata == '0)
        else $error("dropped item carries data");

    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bha_pkg::ST_NEW |-> m_tdata[43:12] == 32'd1)
        else $error("new group count not one");

endmodule
